>>> design/tscf_pkg.sv
// Package for the text stream filter: item types, configuration record,
// register indexes and character codes. No dependencies.
`timescale 1ns / 1ps

package tscf_pkg;

	// Input item: one raw byte of the stream
	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_of_file;
	} in_item_t;

	// Output item: one formatted byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// Option registers as seen by the datapath
	typedef struct packed {
		logic [1:0] number_mode;
		logic       squeeze_blank;
		logic       show_ends;
		logic       show_tabs;
		logic       show_nonprinting;
	} cfg_t;

	// Byte expansion of one item, without the line number
	typedef struct packed {
		logic            has_num;
		logic [1:0]      last_idx;
		logic [3:0][7:0] chars;
	} char_job_t;

	// Register indexes
	localparam logic [2:0] REG_NUMBER_MODE      = 3'd0;
	localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd1;
	localparam logic [2:0] REG_SHOW_ENDS        = 3'd2;
	localparam logic [2:0] REG_SHOW_TABS        = 3'd3;
	localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd4;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [6:0] CH_DEL7   = 7'h7F;

endpackage

>>> design/text_stream_cat_filter.sv
// Top level of the cat-style text stream filter: option registers on an
// APB-style port, front end, job queue and output sequencer. Uses tscf_pkg.
//
//   channel  handshake             payload      role
//   src      src_valid/src_ready   in_item_t    raw stream bytes
//   dst      dst_valid/dst_ready   out_item_t   formatted bytes
//   cfg      psel/penable/pwrite   pwdata       option registers at 4*index
//
// An item is classified in the cycle it is accepted; its first output byte
// reaches the output register after the sequencer loads the job, then one
// byte a cycle while dst_ready holds. The sequencer holds an item until all
// its bytes are out; a numbered line start also sends padding, digits and a tab.
// The two-entry job queue stalls src only when the sequencer is behind.
// Reset clears line state, counter to one and options to zero; no clearing pass.
`timescale 1ns / 1ps

module text_stream_cat_filter
	import tscf_pkg::*;
#(
	parameter int NUMBER_DIGITS = 7,
	parameter int PAD_WIDTH     = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  in_item_t    src_item,
	output logic        dst_valid,
	input  logic        dst_ready,
	output out_item_t   dst_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TW = $clog2(NUMBER_DIGITS);
	localparam int PW = $clog2(PAD_WIDTH + 1);
	localparam int BW = 4 * NUMBER_DIGITS;
	localparam int QW = $bits(char_job_t) + BW + TW + PW;

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	logic            push, push_ready, head_valid, pop;
	char_job_t       job_chars, head_chars;
	logic [BW-1:0]   job_digits, head_digits;
	logic [TW-1:0]   job_top, head_top;
	logic [PW-1:0]   job_pad, head_pad;
	logic [QW-1:0]   head_data;

	// Option registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NUMBER_MODE:      cfg_q.number_mode      <= pwdata[1:0];
				REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= pwdata[0];
				REG_SHOW_ENDS:        cfg_q.show_ends        <= pwdata[0];
				REG_SHOW_TABS:        cfg_q.show_tabs        <= pwdata[0];
				REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (reg_idx)
			REG_NUMBER_MODE:      prdata = {30'd0, cfg_q.number_mode};
			REG_SQUEEZE_BLANK:    prdata = {31'd0, cfg_q.squeeze_blank};
			REG_SHOW_ENDS:        prdata = {31'd0, cfg_q.show_ends};
			REG_SHOW_TABS:        prdata = {31'd0, cfg_q.show_tabs};
			REG_SHOW_NONPRINTING: prdata = {31'd0, cfg_q.show_nonprinting};
			default:              prdata = '0;
		endcase
	end

	tscf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS),
		.PAD_WIDTH    (PAD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.push      (push),
		.push_ready(push_ready),
		.job_chars (job_chars),
		.job_digits(job_digits),
		.job_top   (job_top),
		.job_pad   (job_pad)
	);

	tscf_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.wr_data   ({job_chars, job_digits, job_top, job_pad}),
		.head_valid(head_valid),
		.pop       (pop),
		.head_data (head_data)
	);

	assign {head_chars, head_digits, head_top, head_pad} = head_data;

	tscf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS),
		.PAD_WIDTH    (PAD_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.pop        (pop),
		.head_chars (head_chars),
		.head_digits(head_digits),
		.head_top   (head_top),
		.head_pad   (head_pad),
		.dst_valid  (dst_valid),
		.dst_ready  (dst_ready),
		.dst_item   (dst_item)
	);

endmodule

>>> design/tscf_front.sv
// Front end: accepts items, tracks line state and the BCD line counter,
// and turns each item into a job for the output sequencer. Uses tscf_pkg.
`timescale 1ns / 1ps

module tscf_front
	import tscf_pkg::*;
#(
	parameter int NUMBER_DIGITS = 7,
	parameter int PAD_WIDTH     = 6,
	localparam int TW = $clog2(NUMBER_DIGITS),
	localparam int PW = $clog2(PAD_WIDTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         src_valid,
	output logic                         src_ready,
	input  in_item_t                     src_item,
	output logic                         push,
	input  logic                         push_ready,
	output char_job_t                    job_chars,
	output logic [4*NUMBER_DIGITS-1:0]   job_digits,
	output logic [TW-1:0]                job_top,
	output logic [PW-1:0]                job_pad
);

	localparam int BW = 4 * NUMBER_DIGITS;

	logic          at_line_start_q;
	logic          blank_seen_q;
	logic [BW-1:0] number_q;

	logic          als, bs, nl, tab, drop, print_num, accept;
	logic [BW-1:0] num, num_inc;
	logic          all_nines;
	logic [6:0]    x;

	// Effective state after a file start
	assign als = src_item.first_of_file | at_line_start_q;
	assign bs  = ~src_item.first_of_file & blank_seen_q;
	assign num = src_item.first_of_file ? BW'(1) : number_q;

	assign nl   = (src_item.in_byte == CH_NL);
	assign tab  = (src_item.in_byte == CH_TAB);
	assign drop = als & cfg.squeeze_blank & nl & bs;
	assign print_num = als & (cfg.number_mode[1] ? ~nl : cfg.number_mode[0]);

	assign src_ready = push_ready;
	assign accept    = src_valid & src_ready;
	assign push      = accept & ~drop;

	// BCD increment: a digit steps when all digits below it are nine
	always_comb begin
		logic carry;
		carry = 1'b1;
		num_inc = num;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (carry) begin
				if (num[4*i +: 4] == 4'd9) begin
					num_inc[4*i +: 4] = 4'd0;
				end else begin
					num_inc[4*i +: 4] = num[4*i +: 4] + 4'd1;
				end
			end
			carry = carry & (num[4*i +: 4] == 4'd9);
		end
		all_nines = carry;
	end

	// Highest nonzero digit and padding
	always_comb begin
		int top;
		top = 0;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (num[4*i +: 4] != 4'd0) begin
				top = i;
			end
		end
		job_top = TW'(top);
		job_pad = (PAD_WIDTH > top + 1) ? PW'(PAD_WIDTH - 1 - top) : PW'(0);
	end

	assign job_digits = num;
	assign x = src_item.in_byte[6:0];

	// Byte expansion
	always_comb begin
		logic [1:0] k;
		job_chars = '0;
		job_chars.has_num = print_num;
		k = 2'd0;
		if (nl) begin
			if (cfg.show_ends) begin
				job_chars.chars[0] = CH_DOLLAR;
				job_chars.chars[1] = CH_NL;
				job_chars.last_idx = 2'd1;
			end else begin
				job_chars.chars[0] = CH_NL;
			end
		end else if (tab) begin
			if (cfg.show_tabs) begin
				job_chars.chars[0] = CH_CARET;
				job_chars.chars[1] = CH_I;
				job_chars.last_idx = 2'd1;
			end else begin
				job_chars.chars[0] = CH_TAB;
			end
		end else if (cfg.show_nonprinting) begin
			// high bytes get an M- prefix, then the low seven bits
			if (src_item.in_byte[7]) begin
				job_chars.chars[0] = CH_M;
				job_chars.chars[1] = CH_DASH;
				k = 2'd2;
			end
			if (x[6:5] == 2'b00) begin
				job_chars.chars[k]        = CH_CARET;
				job_chars.chars[k + 2'd1] = {3'b010, x[4:0]};
				job_chars.last_idx        = k + 2'd1;
			end else if (x == CH_DEL7) begin
				job_chars.chars[k]        = CH_CARET;
				job_chars.chars[k + 2'd1] = CH_QMARK;
				job_chars.last_idx        = k + 2'd1;
			end else begin
				job_chars.chars[k] = {1'b0, x};
				job_chars.last_idx = k;
			end
		end else begin
			job_chars.chars[0] = src_item.in_byte;
		end
	end

	// Line state, updated on every kept item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			blank_seen_q    <= 1'b0;
			number_q        <= BW'(1);
		end else if (push) begin
			at_line_start_q <= nl;
			blank_seen_q    <= als ? (cfg.squeeze_blank & nl) : bs;
			if (print_num) begin
				number_q <= all_nines ? BW'(1) : num_inc;
			end else begin
				number_q <= num;
			end
		end
	end

endmodule

>>> design/tscf_queue.sv
// Small register FIFO between the front end and the output sequencer.
// No dependencies.
`timescale 1ns / 1ps

module tscf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             head_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign push_ready = (count_q != CNTW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

>>> design/tscf_back.sv
// Output sequencer, uses tscf_pkg: walks a job through padding, digits, tab
// and byte expansion into an output register, a byte per cycle unless stalled.
`timescale 1ns / 1ps

module tscf_back
	import tscf_pkg::*;
#(
	parameter int NUMBER_DIGITS = 7,
	parameter int PAD_WIDTH     = 6,
	localparam int TW = $clog2(NUMBER_DIGITS),
	localparam int PW = $clog2(PAD_WIDTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	output logic                       pop,
	input  char_job_t                  head_chars,
	input  logic [4*NUMBER_DIGITS-1:0] head_digits,
	input  logic [TW-1:0]              head_top,
	input  logic [PW-1:0]              head_pad,
	output logic                       dst_valid,
	input  logic                       dst_ready,
	output out_item_t                  dst_item
);

	localparam int CW0 = (PW > TW) ? PW : TW;
	localparam int CW  = (CW0 > 2) ? CW0 : 2;

	localparam logic [1:0] PH_PAD = 2'd0;
	localparam logic [1:0] PH_DIG = 2'd1;
	localparam logic [1:0] PH_TAB = 2'd2;
	localparam logic [1:0] PH_CHR = 2'd3;

	logic                       busy_q;
	logic [1:0]                 phase_q;
	logic [CW-1:0]              cnt_q;
	logic [4*NUMBER_DIGITS-1:0] digits_q;
	logic [TW-1:0]              top_q;
	char_job_t                  chars_q;
	logic                       out_valid_q;
	out_item_t                  out_q;

	logic      advance, emit, finish, load;
	out_item_t next_item;
	logic [1:0]    phase_d;
	logic [CW-1:0] cnt_d;

	assign advance = ~out_valid_q | dst_ready;
	assign emit    = busy_q & advance;
	assign load    = head_valid & (~busy_q | finish);
	assign pop     = load;

	// Byte for the current position and the next position
	always_comb begin
		next_item = '0;
		finish    = 1'b0;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		unique case (phase_q)
			PH_PAD: begin
				next_item.out_byte = CH_SPACE;
				if (cnt_q == CW'(1)) begin
					phase_d = PH_DIG;
					cnt_d   = CW'(top_q);
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			PH_DIG: begin
				next_item.out_byte = CH_ZERO + {4'd0, digits_q[4*cnt_q[TW-1:0] +: 4]};
				if (cnt_q == '0) begin
					phase_d = PH_TAB;
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			PH_TAB: begin
				next_item.out_byte = CH_TAB;
				phase_d = PH_CHR;
				cnt_d   = '0;
			end
			PH_CHR: begin
				next_item.out_byte = chars_q.chars[cnt_q[1:0]];
				if (cnt_q[1:0] == chars_q.last_idx) begin
					next_item.last_of_run = 1'b1;
					finish = emit;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			default: begin
				next_item = '0;
			end
		endcase
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_CHR;
			cnt_q   <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			if (!head_chars.has_num) begin
				phase_q <= PH_CHR;
				cnt_q   <= '0;
			end else if (head_pad != '0) begin
				phase_q <= PH_PAD;
				cnt_q   <= CW'(head_pad);
			end else begin
				phase_q <= PH_DIG;
				cnt_q   <= CW'(head_top);
			end
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	// Job payload
	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= head_digits;
			top_q    <= head_top;
			chars_q  <= head_chars;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= next_item;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

endmodule
